// ===== rtl/spd_pkg.sv =====
// shared constants and types for the scale packet deframer
// no dependencies; imported by every module of the block
package spd_pkg;

   localparam int unsigned FRAME_LEN = 7;
   localparam int unsigned HOLD_LEN  = 6;

   localparam logic [7:0] MARKER        = 8'h03;
   localparam logic [7:0] TYPE_WEIGHT_A = 8'hCE;
   localparam logic [7:0] TYPE_WEIGHT_B = 8'hCA;
   localparam logic [7:0] TYPE_BATTERY  = 8'h0A;
   localparam logic [7:0] TYPE_BUTTON   = 8'hAA;
   localparam logic [7:0] BATT_CHARGING = 8'hFF;
   localparam logic [7:0] BATT_FULL     = 8'd100;

   localparam logic [1:0] KIND_WEIGHT  = 2'd0;
   localparam logic [1:0] KIND_BATTERY = 2'd1;
   localparam logic [1:0] KIND_BUTTON  = 2'd2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic     good;
      byte_type frame_kind;
      byte_type body2;
      byte_type body3;
      byte_type body4;
   } frame_type;

endpackage

// ===== rtl/spd_window.sv =====
// byte window and frame search: holds up to six bytes and checks each full frame
// depends on spd_pkg
module spd_window (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  spd_pkg::byte_type new_byte,
   output spd_pkg::frame_type frame
);
   import spd_pkg::*;

   byte_type   win_ff [HOLD_LEN];
   byte_type   win_in [HOLD_LEN];
   logic [2:0] count_ff;
   logic [2:0] count_in;

   byte_type   buf_b [FRAME_LEN];
   logic [2:0] pos;
   logic       found;
   byte_type   chk;
   logic       full;

   always_comb begin
      for (int i = 0; i < HOLD_LEN; i++) begin
         buf_b[i] = win_ff[i];
      end
      buf_b[FRAME_LEN-1] = new_byte;

      full  = (count_ff >= 3'(HOLD_LEN));
      found = 1'b0;
      pos   = 3'd0;
      for (int i = FRAME_LEN - 1; i >= 0; i--) begin
         if (buf_b[i] == MARKER) begin
            found = 1'b1;
            pos   = 3'(i);
         end
      end

      chk = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         chk = chk ^ buf_b[i];
      end

      for (int i = 0; i < HOLD_LEN; i++) begin
         win_in[i] = win_ff[i];
      end
      count_in   = count_ff;
      frame      = '0;
      frame.frame_kind = buf_b[1];
      frame.body2      = buf_b[2];
      frame.body3      = buf_b[3];
      frame.body4      = buf_b[4];

      if (!full) begin
         win_in[count_ff] = new_byte;
         count_in = count_ff + 3'd1;
      end else if (!found) begin
         count_in = 3'd0;
      end else if (pos != 3'd0) begin
         for (int p = 1; p < FRAME_LEN; p++) begin
            if (pos == 3'(p)) begin
               for (int i = 0; i < FRAME_LEN - p; i++) begin
                  win_in[i] = buf_b[i+p];
               end
            end
         end
         count_in = 3'(FRAME_LEN) - pos;
      end else if (chk != buf_b[FRAME_LEN-1]) begin
         for (int i = 0; i < HOLD_LEN; i++) begin
            win_in[i] = buf_b[i+1];
         end
         count_in = 3'(HOLD_LEN);
      end else begin
         count_in   = 3'd0;
         frame.good = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < HOLD_LEN; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

// ===== rtl/spd_result.sv =====
// frame decode by type byte and the result register of the rsp channel
// depends on spd_pkg
module spd_result (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  spd_pkg::frame_type frame,
   output logic               rsp_valid,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_weight_tenths,
   output logic [6:0]         rsp_battery_percent,
   output logic [7:0]         rsp_button_id
);
   import spd_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic               hit;
   logic [1:0]         kind_in;
   logic signed [15:0] weight_in;
   logic [6:0]         batt_in;
   logic [7:0]         button_in;
   logic [1:0]         kind_ff;
   logic signed [15:0] weight_ff;
   logic [6:0]         batt_ff;
   logic [7:0]         button_ff;

   always_comb begin
      hit       = 1'b0;
      kind_in   = KIND_WEIGHT;
      weight_in = '0;
      batt_in   = '0;
      button_in = '0;
      if (frame.frame_kind == TYPE_WEIGHT_A || frame.frame_kind == TYPE_WEIGHT_B) begin
         hit       = 1'b1;
         weight_in = {frame.body2, frame.body3};
      end else if (frame.frame_kind == TYPE_BATTERY) begin
         kind_in = KIND_BATTERY;
         if (frame.body4 <= BATT_FULL) begin
            hit     = 1'b1;
            batt_in = frame.body4[6:0];
         end else if (frame.body4 == BATT_CHARGING) begin
            hit     = 1'b1;
            batt_in = BATT_FULL[6:0];
         end
      end else if (frame.frame_kind == TYPE_BUTTON) begin
         hit       = 1'b1;
         kind_in   = KIND_BUTTON;
         button_in = frame.body2;
      end
      valid_in = frame.good && hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && valid_in) begin
         kind_ff   <= kind_in;
         weight_ff <= weight_in;
         batt_ff   <= batt_in;
         button_ff <= button_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_weight_tenths   = weight_ff;
   assign rsp_battery_percent = batt_ff;
   assign rsp_button_id       = button_ff;

endmodule

// ===== rtl/scale_packet_deframer.sv =====
// top level of the scale packet deframer: input register, window search, decode
// depends on spd_pkg, spd_window and spd_result
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_in_byte
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_kind, rsp_weight_tenths,
//          |           |                      | rsp_battery_percent, rsp_button_id
//
// one byte per cycle sustained unless a held result stalls the pipe; a byte waits in
// the input register and its result, if any, is then written to the result register
// the window update for a byte is computed by the combinational search logic
// reset clears the window count and both valid flags
// a result held in the result register stalls the pipe; with the input register
// full, req_ready then follows rsp_ready
module scale_packet_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_weight_tenths,
   output logic [6:0]         rsp_battery_percent,
   output logic [7:0]         rsp_button_id
);
   import spd_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   byte_type  in_byte_ff;
   logic      advance;
   logic      step;
   frame_type frame;

   assign advance   = !rsp_valid || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   spd_window u_window (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .new_byte (in_byte_ff),
      .frame    (frame)
   );

   spd_result u_result (
      .clock               (clock),
      .reset               (reset),
      .step                (advance),
      .frame               (frame),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_weight_tenths   (rsp_weight_tenths),
      .rsp_battery_percent (rsp_battery_percent),
      .rsp_button_id       (rsp_button_id)
   );

endmodule
